// File: hw/rtl/u23alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u23alu_pkg
// Opcodes, controller states and the command/status bundles shared by the
// controller and the datapath of the unsigned integer alu.
// ----------------------------------------------------------------------------
package u23alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_SHL = 4'd5,
    OP_SHR = 4'd6,
    OP_LT  = 4'd7,
    OP_LE  = 4'd8,
    OP_GT  = 4'd9,
    OP_GE  = 4'd10,
    OP_EQ  = 4'd11
  } u23alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_DONE
  } u23alu_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture an input beat
    logic step;    // one shift-add or restoring-divide iteration
    logic finish;  // write the output register
  } u23alu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iter;    // opcode needs the bit-serial loop
    logic last;    // current iteration is the final one
  } u23alu_sts_t;

endpackage

// File: hw/rtl/u23alu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u23alu request and response channels
// Valid/ready channels carrying the operation beat in and the result beat out.
// ----------------------------------------------------------------------------
interface u23alu_req_if #(
  parameter int WIDTH = 23
);
  logic             valid;
  logic             ready;
  logic [3:0]       opcode;
  logic [WIDTH-1:0] operand_a;
  logic [WIDTH-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

interface u23alu_rsp_if #(
  parameter int WIDTH = 23
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  logic             compare_true;
  logic             status;

  modport source (output valid, output result, output compare_true, output status,
                  input ready);
  modport sink   (input valid, input result, input compare_true, input status,
                  output ready);
endinterface

// File: hw/rtl/u23alu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u23alu_ctrl
// Controller: sequences load, iterate and finish, and owns the output valid.
// ----------------------------------------------------------------------------
module u23alu_ctrl
  import u23alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output u23alu_cmd_t cmd,
  input  u23alu_sts_t sts
);

  u23alu_state_t state;
  u23alu_state_t state_next;
  logic          out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        cmd.step = sts.iter;
        if (!sts.iter || sts.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // output register is free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: hw/rtl/u23alu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u23alu_dp
// Datapath: operand registers, shift-add multiplier, restoring divider and
// the result register.
// ----------------------------------------------------------------------------
module u23alu_dp
  import u23alu_pkg::*;
#(
  parameter int WIDTH = 23
) (
  input  logic             clk,
  input  u23alu_cmd_t      cmd,
  output u23alu_sts_t      sts,
  input  logic [3:0]       opcode,
  input  logic [WIDTH-1:0] operand_a,
  input  logic [WIDTH-1:0] operand_b,
  output logic [WIDTH-1:0] result,
  output logic             compare_true,
  output logic             status
);

  localparam int CW = $clog2(WIDTH);

  u23alu_op_t       op_q;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [WIDTH-1:0] x;      // multiplicand, or dividend becoming quotient
  logic [WIDTH-1:0] y;      // multiplier, or divisor
  logic [WIDTH:0]   acc;    // product, or partial remainder
  logic [CW-1:0]    count;

  logic [WIDTH:0]   rem_shift;
  logic [WIDTH:0]   rem_sub;
  logic             fits;
  logic [WIDTH-1:0] mul_sum;
  logic [WIDTH-1:0] res_c;
  logic             flag_c;
  logic             err_c;

  assign rem_shift = {acc[WIDTH-1:0], x[WIDTH-1]};
  assign fits      = rem_shift >= {1'b0, y};
  assign rem_sub   = rem_shift - {1'b0, y};
  assign mul_sum   = acc[WIDTH-1:0] + x;

  always_comb begin
    sts.iter = op_q inside {OP_MUL, OP_DIV, OP_MOD};
    sts.last = (count == CW'(WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= u23alu_op_t'(opcode);
      a_q   <= operand_a;
      b_q   <= operand_b;
      x     <= operand_a;
      y     <= operand_b;
      acc   <= '0;
      count <= '0;
    end else if (cmd.step) begin
      count <= count + 1'b1;
      if (op_q == OP_MUL) begin
        acc <= {1'b0, (y[0] ? mul_sum : acc[WIDTH-1:0])};
        x   <= x << 1;
        y   <= y >> 1;
      end else begin
        acc <= fits ? rem_sub : rem_shift;
        x   <= {x[WIDTH-2:0], fits};
      end
    end
  end

  always_comb begin
    res_c  = '0;
    flag_c = 1'b0;
    err_c  = 1'b0;
    case (op_q)
      OP_ADD: res_c = a_q + b_q;
      OP_SUB: res_c = a_q - b_q;
      OP_MUL: res_c = acc[WIDTH-1:0];
      OP_DIV: begin
        if (b_q == '0) begin
          err_c = 1'b1;
        end else begin
          res_c = x;
        end
      end
      OP_MOD: begin
        if (b_q == '0) begin
          err_c = 1'b1;
        end else begin
          res_c = acc[WIDTH-1:0];
        end
      end
      OP_SHL: res_c = (b_q >= WIDTH'(WIDTH)) ? '0 : (a_q << b_q);
      OP_SHR: res_c = (b_q >= WIDTH'(WIDTH)) ? '0 : (a_q >> b_q);
      OP_LT:  flag_c = a_q < b_q;
      OP_LE:  flag_c = a_q <= b_q;
      OP_GT:  flag_c = a_q > b_q;
      OP_GE:  flag_c = a_q >= b_q;
      OP_EQ:  flag_c = a_q == b_q;
      default: begin
        res_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result       <= res_c;
      compare_true <= flag_c;
      status       <= err_c;
    end
  end

endmodule

// File: hw/rtl/uint23_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint23_alu
// Unsigned integer alu: add, sub, shift-add multiply, restoring divide and
// remainder, shifts and compares, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel  role    beat contents
//  req      sink    opcode, operand_a, operand_b
//  rsp      source  result, compare_true, status
//
//  mul, div and mod run one loop iteration per bit in the shared
//  shift/subtract datapath before their result is written; all other
//  opcodes pass through the busy and done states without iterating. A new
//  request is taken once the previous result sits in the output register,
//  so rsp stalls do not hold up work until a second result is ready. Reset
//  clears the controller and out valid.
// ----------------------------------------------------------------------------
module uint23_alu
  import u23alu_pkg::*;
#(
  parameter int WIDTH = 23
) (
  input logic          clk,
  input logic          rst,
  u23alu_req_if.sink   req,
  u23alu_rsp_if.source rsp
);

  u23alu_cmd_t cmd;
  u23alu_sts_t sts;

  u23alu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  u23alu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (req.opcode),
    .operand_a    (req.operand_a),
    .operand_b    (req.operand_b),
    .result       (rsp.result),
    .compare_true (rsp.compare_true),
    .status       (rsp.status)
  );

endmodule

// File: hw/rtl/u23alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u23alu_checker
// Port-level checks on the alu channels, bound to the top level.
// ----------------------------------------------------------------------------
module u23alu_checker #(
  parameter int WIDTH = 23
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] result,
  input logic             compare_true,
  input logic             status
);

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("result beat dropped or changed while stalled");

  // one request in flight: accept closes the request side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  // a true compare beat carries no result and no error
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result == '0 && !status)
    else $error("compare beat with nonzero result or error");

  // divide or remainder by zero gives a clean zero result
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result == '0 && !compare_true)
    else $error("error beat with nonzero result or flag");

endmodule

bind uint23_alu u23alu_checker #(
  .WIDTH (WIDTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .result       (rsp.result),
  .compare_true (rsp.compare_true),
  .status       (rsp.status)
);
